FILE: rtl/spmd_pkg.sv
`timescale 1ns / 1ps

package spmd_pkg;

    // Field and register widths
    localparam int CFG_W   = 16;
    localparam int DUTY_W  = 7;
    localparam int IDX_W   = 2;
    localparam int PROD_W  = CFG_W + DUTY_W;   // period * duty
    localparam int NUM_W   = CFG_W + DUTY_W;   // min_state * 100

    localparam int COUNT_BITS_DEF = 16;

    // Percent scale
    localparam int PCT = 100;
    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(PCT);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_PERIOD     = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_STATE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ACTIVE_LOW = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] PERIOD_RESET    = 16'd1000;
    localparam logic [CFG_W-1:0] MIN_STATE_RESET = 16'd100;
    localparam logic             ACTIVE_LOW_RESET = 1'b1;

    // Duty floor that matches the reset configuration
    localparam int FLOOR_RESET_RAW = (100 * PCT) / 1000;
    localparam logic [DUTY_W-1:0] FLOOR_RESET =
        DUTY_W'((FLOOR_RESET_RAW > PCT) ? PCT : FLOOR_RESET_RAW);

    // Live configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] period_eff;
        logic [CFG_W-1:0] min_state;
        logic             active_low;
    } t_cfg;

    // First pipeline stage contents
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [PROD_W-1:0] on_prod;
    } t_s1;

endpackage

FILE: rtl/spmd_floor_div.sv
`timescale 1ns / 1ps

// Restoring divider: floor = min(min_state * 100 / period, 100), one bit per cycle
module spmd_floor_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [spmd_pkg::CFG_W-1:0]       i_min_state,
    input  logic [spmd_pkg::CFG_W-1:0]       i_period_eff,
    output logic                             o_busy,
    output logic [spmd_pkg::DUTY_W-1:0]      o_floor
);

    localparam int NW    = spmd_pkg::NUM_W;
    localparam int DW    = spmd_pkg::CFG_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [spmd_pkg::DUTY_W-1:0] r_floor;
    logic [NW-1:0]     r_num;
    logic [NW-1:0]     r_quo;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_div;

    logic [DW:0]       rem_sh;
    logic [DW:0]       rem_sub;
    logic              fits;
    logic [DW-1:0]     n_rem;
    logic [NW-1:0]     n_quo;
    logic [spmd_pkg::DUTY_W-1:0] n_floor;

    // One quotient bit per step
    always_comb begin
        rem_sh  = {r_rem, r_num[NW-1]};
        fits    = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
        n_rem   = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        n_quo   = {r_quo[NW-2:0], fits};
        n_floor = (n_quo > NW'(spmd_pkg::PCT)) ? spmd_pkg::DUTY_FULL
                                               : n_quo[spmd_pkg::DUTY_W-1:0];
    end

    // Control and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_floor <= spmd_pkg::FLOOR_RESET;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy  <= 1'b0;
                r_floor <= n_floor;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NW'(i_min_state) * NW'(spmd_pkg::PCT);
            r_quo <= '0;
            r_rem <= '0;
            r_div <= i_period_eff;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy  = r_busy;
    assign o_floor = r_floor;

`ifndef SYNTHESIS
    // Floor never exceeds full scale
    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_floor <= spmd_pkg::DUTY_FULL)
        else $error("duty floor above full scale");
`endif

endmodule

FILE: rtl/spmd_duty_stage.sv
`timescale 1ns / 1ps

// Input stage: saturate and clamp the duty, form period * duty
module spmd_duty_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [spmd_pkg::DUTY_W-1:0]    i_duty_request,
    input  logic                           i_hold,
    input  logic                           i_ready,
    input  logic [spmd_pkg::DUTY_W-1:0]    i_floor,
    input  logic [spmd_pkg::CFG_W-1:0]     i_period_eff,
    output logic                           o_in_stall,
    output logic                           o_valid,
    output spmd_pkg::t_s1                  o_s1
);

    localparam int PW = spmd_pkg::PROD_W;

    logic                         r_valid;
    spmd_pkg::t_s1                r_s1;

    logic                         can_take;
    logic                         accept;
    logic [spmd_pkg::DUTY_W-1:0]  req;
    logic [spmd_pkg::DUTY_W-1:0]  hi;
    logic [spmd_pkg::DUTY_W-1:0]  duty;

    assign can_take   = !r_valid || i_ready;
    assign o_in_stall = i_hold || !can_take;
    assign accept     = i_in_valid && !o_in_stall;

    // Saturate, pass 0 and 100 through, else clamp to [floor, 100 - floor] testing the low bound first
    always_comb begin
        req = (i_duty_request > spmd_pkg::DUTY_FULL) ? spmd_pkg::DUTY_FULL
                                                     : i_duty_request;
        hi  = spmd_pkg::DUTY_FULL - i_floor;
        if (req == '0 || req == spmd_pkg::DUTY_FULL) begin
            duty = req;
        end else if (req < i_floor) begin
            duty = i_floor;
        end else if (req > hi) begin
            duty = hi;
        end else begin
            duty = req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (can_take) begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.duty    <= duty;
            r_s1.on_prod <= PW'(i_period_eff) * PW'(duty);
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

FILE: rtl/spmd_tick_core.sv
`timescale 1ns / 1ps

// Tick state (phase, dwell counter, relay) and the result register
module spmd_tick_core #(
    parameter int COUNT_BITS = spmd_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  spmd_pkg::t_s1                  i_s1,
    input  spmd_pkg::t_cfg                 i_cfg,
    input  logic                           i_out_stall,
    output logic                           o_ready,
    output logic                           o_out_valid,
    output logic                           o_pin_level,
    output logic                           o_relay_on,
    output logic [spmd_pkg::DUTY_W-1:0]    o_applied_duty,
    output logic                           o_toggled
);

    // 100 * (phase + 1) needs 7 more bits than the phase
    localparam int X_W = (COUNT_BITS + 7 > spmd_pkg::PROD_W) ? COUNT_BITS + 7
                                                             : spmd_pkg::PROD_W;
    localparam int N_W = (COUNT_BITS + 1 > spmd_pkg::CFG_W) ? COUNT_BITS + 1
                                                            : spmd_pkg::CFG_W;
    localparam int S_W = (COUNT_BITS > spmd_pkg::CFG_W) ? COUNT_BITS
                                                        : spmd_pkg::CFG_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [COUNT_BITS-1:0]        r_phase;
    logic [X_W-1:0]               r_phase_x100;
    logic [COUNT_BITS-1:0]        r_since;
    logic                         r_on;
    logic                         r_out_valid;
    logic                         r_out_pin;
    logic                         r_out_relay;
    logic [spmd_pkg::DUTY_W-1:0]  r_out_duty;
    logic                         r_out_toggled;

    logic                         advance;
    logic                         want;
    logic                         flip;
    logic [COUNT_BITS-1:0]        since_base;
    logic [COUNT_BITS-1:0]        n_since;
    logic [N_W-1:0]               phase_inc;
    logic                         wrap;
    logic [COUNT_BITS-1:0]        n_phase;
    logic [X_W-1:0]               n_phase_x100;
    logic                         n_on;

    assign o_ready = !r_out_valid || !i_out_stall;
    assign advance = i_valid && o_ready;

    // phase < floor(period*duty/100)  <=>  100*(phase+1) <= period*duty
    always_comb begin
        want       = (r_phase_x100 <= X_W'(i_s1.on_prod));
        flip       = (want != r_on) && (S_W'(r_since) >= S_W'(i_cfg.min_state));
        n_on       = flip ? want : r_on;
        since_base = flip ? '0 : r_since;
        n_since    = (since_base != CMAX) ? since_base + COUNT_BITS'(1) : since_base;
        phase_inc  = N_W'(r_phase) + N_W'(1);
        wrap       = (phase_inc >= N_W'(i_cfg.period_eff)) || (phase_inc > N_W'(CMAX));
        n_phase    = wrap ? '0 : phase_inc[COUNT_BITS-1:0];
        n_phase_x100 = wrap ? X_W'(spmd_pkg::PCT) : r_phase_x100 + X_W'(spmd_pkg::PCT);
    end

    // Tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_phase_x100 <= X_W'(spmd_pkg::PCT);
            r_since      <= '0;
            r_on         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (advance) begin
                r_phase      <= n_phase;
                r_phase_x100 <= n_phase_x100;
                r_since      <= n_since;
                r_on         <= n_on;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pin     <= n_on ^ i_cfg.active_low;
            r_out_relay   <= n_on;
            r_out_duty    <= i_s1.duty;
            r_out_toggled <= flip;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pin_level    = r_out_pin;
    assign o_relay_on     = r_out_relay;
    assign o_applied_duty = r_out_duty;
    assign o_toggled      = r_out_toggled;

`ifndef SYNTHESIS
    // Scaled phase tracks the phase counter
    a_phase_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase_x100 == X_W'(r_phase) * X_W'(spmd_pkg::PCT) + X_W'(spmd_pkg::PCT))
        else $error("scaled phase out of step with phase counter");

    // A toggle restarts the dwell count
    a_dwell_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && flip) |=> (r_since == COUNT_BITS'(1)) && (r_on != $past(r_on)))
        else $error("toggle did not restart dwell counter");

    // Shown relay state is the held relay state
    a_relay_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_relay == r_on))
        else $error("result relay state differs from held state");
`endif

endmodule

FILE: rtl/slow_pwm_min_dwell.sv
`timescale 1ns / 1ps
// A result is offered by the result register after the input stage registers its input.
// Throughput: one transaction per cycle unless stalled; input stage and result register overlap.
// A write to period_ms or min_state_ms stalls the input while the restoring divider
// (one quotient bit a cycle) recomputes the duty floor.
// Synchronous active-low reset: registers take their reset values, relay off, floor 10.

module slow_pwm_min_dwell #(
    parameter int COUNT_BITS = spmd_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spmd_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [spmd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [spmd_pkg::DUTY_W-1:0]    i_duty_request,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_pin_level,
    output logic                           o_relay_on,
    output logic [spmd_pkg::DUTY_W-1:0]    o_applied_duty,
    output logic                           o_toggled
);

    logic [spmd_pkg::CFG_W-1:0]   r_period;
    logic [spmd_pkg::CFG_W-1:0]   r_min_state;
    logic                         r_active_low;
    logic                         r_div_start;
    logic                         n_div_start;

    spmd_pkg::t_cfg               cfg;
    logic                         div_busy;
    logic [spmd_pkg::DUTY_W-1:0]  floor_val;
    logic                         s1_valid;
    spmd_pkg::t_s1                s1;
    logic                         core_ready;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= spmd_pkg::PERIOD_RESET;
            r_min_state  <= spmd_pkg::MIN_STATE_RESET;
            r_active_low <= spmd_pkg::ACTIVE_LOW_RESET;
            r_div_start  <= 1'b0;
        end else begin
            r_div_start <= n_div_start;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    spmd_pkg::REG_PERIOD:     r_period     <= i_cfg_data;
                    spmd_pkg::REG_MIN_STATE:  r_min_state  <= i_cfg_data;
                    spmd_pkg::REG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Floor recompute starts the cycle after a period or dwell write
    assign n_div_start = i_cfg_we && (i_cfg_index == spmd_pkg::REG_PERIOD ||
                                      i_cfg_index == spmd_pkg::REG_MIN_STATE);

    always_comb begin
        cfg.period_eff = (r_period == '0) ? spmd_pkg::CFG_W'(1) : r_period;
        cfg.min_state  = r_min_state;
        cfg.active_low = r_active_low;
    end

    spmd_floor_div u_floor_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_div_start),
        .i_min_state  (r_min_state),
        .i_period_eff (cfg.period_eff),
        .o_busy       (div_busy),
        .o_floor      (floor_val)
    );

    spmd_duty_stage u_duty_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_duty_request (i_duty_request),
        .i_hold         (div_busy || r_div_start),
        .i_ready        (core_ready),
        .i_floor        (floor_val),
        .i_period_eff   (cfg.period_eff),
        .o_in_stall     (o_in_stall),
        .o_valid        (s1_valid),
        .o_s1           (s1)
    );

    spmd_tick_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tick_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s1_valid),
        .i_s1           (s1),
        .i_cfg          (cfg),
        .i_out_stall    (i_out_stall),
        .o_ready        (core_ready),
        .o_out_valid    (o_out_valid),
        .o_pin_level    (o_pin_level),
        .o_relay_on     (o_relay_on),
        .o_applied_duty (o_applied_duty),
        .o_toggled      (o_toggled)
    );

endmodule
